// ===== rtl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Shared types, sizes and codes for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int MAP_WORDS  = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam logic [31:0] TOTAL_PAGES = 32'(MAP_WORDS * 32);

   localparam logic [31:0] POOL_BASE_RESET = 32'h0040_0000;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] CSR_POOL_BASE = 1'b0;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_NONE = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] page_address;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] granted_address;
   } rsp_item_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

endpackage

// ===== rtl/pba_core.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator core
// Bitmap memory, per-word summary bits and the read-modify-write sequencer.
// ----------------------------------------------------------------------------
module pba_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  pba_pkg::req_item_type req,
   input  logic [31:0]           pool_base,
   input  logic                  out_free,
   output pba_pkg::core_status_type status,
   output pba_pkg::rsp_item_type result
);
   import pba_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WORK = 1'b1;

   logic                  state_ff, state_in;
   logic                  op_ff;
   logic [WORD_W-1:0]     word_ff;
   logic [4:0]            bit_ff;
   logic [1:0]            code_ff;
   logic [31:0]           rd_data_ff;
   logic                  rd_valid_ff;
   logic [31:0]           mem_ff [MAP_WORDS];
   logic [MAP_WORDS-1:0]  entry_valid_ff;
   logic [MAP_WORDS-1:0]  summary_ff;

   logic [WORD_W-1:0]     alloc_word;
   logic [31:0]           offset;
   logic [31:0]           free_page;
   logic                  free_bad;
   logic [WORD_W-1:0]     rd_addr;
   logic [1:0]            code_in;
   logic [31:0]           cur_word;
   logic [4:0]            pos;
   logic [31:0]           new_word;
   logic                  finish;
   logic                  wr_en;

   always_comb begin
      alloc_word = '0;
      for (int i = MAP_WORDS - 1; i >= 0; i--) begin
         if (summary_ff[i]) begin
            alloc_word = WORD_W'(i);
         end
      end
   end

   assign offset    = req.page_address - pool_base;
   assign free_page = offset >> PAGE_SHIFT;
   assign free_bad  = (req.page_address < pool_base) ||
                      (offset[PAGE_SHIFT-1:0] != '0) ||
                      (free_page >= TOTAL_PAGES);

   always_comb begin
      if (req.req_type == REQ_ALLOC) begin
         rd_addr = alloc_word;
         code_in = (summary_ff != '0) ? STATUS_DONE : STATUS_NONE;
      end else begin
         rd_addr = free_page[WORD_W+4:5];
         code_in = free_bad ? STATUS_BAD : STATUS_DONE;
      end
   end

   assign cur_word = rd_valid_ff ? rd_data_ff : '1;

   always_comb begin
      pos = '0;
      for (int i = 0; i < 32; i++) begin
         if (cur_word[i]) begin
            pos = 5'(31 - i);
         end
      end
   end

   assign new_word = (op_ff == REQ_ALLOC) ? (cur_word & ~(32'h8000_0000 >> pos))
                                          : (cur_word | (32'h8000_0000 >> bit_ff));
   assign finish   = (state_ff == ST_WORK) && out_free;
   assign wr_en    = finish && (code_ff == STATUS_DONE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_valid_ff <= '0;
         summary_ff     <= '1;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            entry_valid_ff[word_ff] <= 1'b1;
            summary_ff[word_ff]     <= (new_word != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == ST_IDLE) begin
         op_ff       <= req.req_type;
         word_ff     <= rd_addr;
         bit_ff      <= free_page[4:0];
         code_ff     <= code_in;
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= entry_valid_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[word_ff] <= new_word;
      end
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = finish;

   assign result.status = code_ff;
   assign result.granted_address = (op_ff == REQ_ALLOC && code_ff == STATUS_DONE) ?
                                   pool_base + (32'({word_ff, pos}) << PAGE_SHIFT) : '0;

endmodule

// ===== rtl/page_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator unit
// Allocates and frees fixed-size pages of a pool tracked in a bitmap memory.
//
//   Channel   Direction   Handshake            Payload
//   req       in          req_valid/req_ready  req_item (req_type, page_address)
//   rsp       out         rsp_valid/rsp_ready  rsp_item (status, granted_address)
//   csr       in/out      APB psel/penable     pool_base at byte address 0
//
// A new item is accepted only while idle; the accept cycle registers the
// addressed bitmap word, and the work state modifies the word read and writes
// it back, waiting while the result register still holds an untaken item.
// After reset every page is free at once; per-word valid bits stand in for
// the initial fill, so there is no clearing pass.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  pba_pkg::req_item_type            req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output pba_pkg::rsp_item_type            rsp_item,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pba_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import pba_pkg::*;

   logic [31:0]     pool_base_ff;
   logic            rsp_valid_ff;
   rsp_item_type    rsp_item_ff;
   logic            out_free;
   core_status_type core_status;
   rsp_item_type    core_result;
   logic            sel_pool_base;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign sel_pool_base = (paddr[CSR_ADDR_W-1] == CSR_POOL_BASE);

   pba_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && req_ready),
      .req       (req_item),
      .pool_base (pool_base_ff),
      .out_free  (out_free),
      .status    (core_status),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= POOL_BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && sel_pool_base) begin
            pool_base_ff <= pwdata;
         end
         if (core_status.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (core_status.done) begin
         rsp_item_ff <= core_result;
      end
   end

   assign req_ready = core_status.idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign prdata    = sel_pool_base ? pool_base_ff : '0;
   assign pready    = 1'b1;

endmodule

// ===== rtl/pba_checker.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator checker
// Port-level assertions, bound to the allocator top level.
// ----------------------------------------------------------------------------
module pba_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input pba_pkg::rsp_item_type rsp_item
);
   import pba_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("Result item changed or dropped while stalled.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == STATUS_DONE || rsp_item.status == STATUS_NONE ||
                     rsp_item.status == STATUS_BAD))
      else $error("Result item carries an undefined status.");

   a_zero_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != STATUS_DONE |-> rsp_item.granted_address == '0)
      else $error("Failed request returned a nonzero address.");

   a_two_cycles: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request taken in the cycle after an accepted item.");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
